// ===== hdl/fcrp_pkg.sv =====
// Constants shared by the fixed-column record field parser and its field RAM.
// Character codes, field numbering, column limits and beat widths.
// No dependencies.
package fcrp_pkg;

    // column geometry
    localparam int COL_W     = 7;
    localparam logic [COL_W-1:0] REC_COLS = 7'd72;
    localparam logic [COL_W-1:0] COL_MAX  = 7'd127;

    // 8-column field groups within a line
    localparam logic [3:0] GRP_LINE1_END = 4'd8;   // groups 0-7 are line-one integers
    localparam logic [3:0] GRP_STATUS    = 4'd8;   // line one columns 65-72
    localparam logic [3:0] GRP_L2_FIRST  = 4'd1;
    localparam logic [3:0] GRP_L2_LAST   = 4'd4;
    localparam logic [3:0] GRP_LABEL     = 4'd7;
    localparam logic [3:0] GRP_SUB       = 4'd8;

    // field identifiers
    localparam int FIELD_COUNT = 18;
    localparam int ID_W        = 5;
    localparam logic [ID_W-1:0] ID_STATUS_BASE = 5'd8;
    localparam logic [ID_W-1:0] ID_L2_BASE     = 5'd11;
    localparam logic [ID_W-1:0] ID_LABEL       = 5'd16;
    localparam logic [ID_W-1:0] ID_SUB         = 5'd17;
    localparam logic [ID_W-1:0] ID_LAST        = 5'd17;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // datapath widths
    localparam int ACC_W  = 27;
    localparam int VAL_W  = 28;
    localparam int STAT_W = 13;
    localparam int LBL_W  = 64;
    localparam int LEN_W  = 4;

    // field RAM: two banks of FIELD_COUNT entries
    localparam int RAM_DEPTH = 2 * FIELD_COUNT;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // beat widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 104;

endpackage

// ===== hdl/fcrp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while rd_en is low. No dependencies.
module fcrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/fixed_column_record_field_parser.sv =====
// Fixed-column record field parser: top level. Uses fcrp_pkg and fcrp_ram.
// Throughput: one character beat per cycle unless stalled; 18 result beats per record at one per cycle
// while m_tready is high, a short record giving one error beat. Path: issue reg, RAM read, output reg.
// Line-two beats stall only while the previous record's results are still draining.
// Reset: synchronous, active-low aresetn clears parse state, bank select and drain control;
// the field RAM is not cleared; each entry whose value is output is written before it is read.
module fixed_column_record_field_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input characters
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fcrp_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic                            s_tlast,   // line_end
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fcrp_pkg::M_TDATA_W-1:0]  m_tdata,   // [4:0] field_id, [32:5] value,
                                                       // [96:33] label_text,
                                                       // [100:97] label_length, rest zero
    output logic                            m_tuser,   // error
    output logic                            m_tlast    // last
);

    import fcrp_pkg::*;

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    logic              on2_reg, on2_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic              seen_reg, seen_next;
    logic [7:0]        held_reg, held_next;
    logic [LBL_W-1:0]  lab_reg, lab_next;
    logic [LEN_W-1:0]  lcnt_reg, lcnt_next;
    logic              short1_reg, short1_next;
    logic              bank_reg, bank_next;     // RAM bank written by the current record

    // drain side
    logic              iss_act_reg, iss_act_next;   // reads still to issue
    logic              iss_err_reg, iss_err_next;   // drain is the single error beat
    logic [ID_W-1:0]   iss_cnt_reg, iss_cnt_next;
    logic              dbank_reg, dbank_next;       // bank being drained
    logic [LBL_W-1:0]  snap_text_reg;
    logic [LEN_W-1:0]  snap_len_reg;
    logic              rd_vld_reg, rd_vld_next;     // RAM read data not yet taken
    logic              rd_err_reg;
    logic [ID_W-1:0]   rd_id_reg;
    logic              m_vld_reg, m_vld_next;
    logic [ID_W-1:0]   m_id_reg;
    logic [VAL_W-1:0]  m_val_reg;
    logic [LBL_W-1:0]  m_text_reg;
    logic [LEN_W-1:0]  m_len_reg;
    logic              m_err_reg;
    logic              m_last_reg;

    // ------------------------------------------------------------------
    // Character decode
    // ------------------------------------------------------------------
    logic [7:0]       ch;
    logic             s_acc;
    logic             drain_busy;
    logic [3:0]       grp;
    logic [2:0]       pos;
    logic             in_rec;
    logic             int_act, stat_act, lab_act;
    logic [ID_W-1:0]  int_id;
    logic [COL_W-1:0] col_inc;
    logic             rec_end, short_rec;

    assign ch         = s_tdata[7:0];
    assign drain_busy = iss_act_reg | rd_vld_reg;
    // a line-two character waits until the earlier record has left the RAM bank
    assign s_tready   = ~(on2_reg & drain_busy);
    assign s_acc      = s_tvalid & s_tready;

    assign grp     = col_reg[COL_W-1:3];
    assign pos     = col_reg[2:0];
    assign in_rec  = col_reg < REC_COLS;
    assign col_inc = (col_reg == COL_MAX) ? col_reg : col_reg + 7'd1;

    always_comb begin
        int_act  = 1'b0;
        stat_act = 1'b0;
        lab_act  = 1'b0;
        int_id   = {1'b0, grp};
        if (in_rec) begin
            if (!on2_reg) begin
                if (grp < GRP_LINE1_END) begin
                    int_act = 1'b1;
                end else if (grp == GRP_STATUS) begin
                    stat_act = 1'b1;
                end
            end else begin
                if (grp >= GRP_L2_FIRST && grp <= GRP_L2_LAST) begin
                    int_act = 1'b1;
                    int_id  = ID_L2_BASE + {1'b0, grp};
                end else if (grp == GRP_LABEL) begin
                    lab_act = 1'b1;
                end else if (grp == GRP_SUB) begin
                    int_act = 1'b1;
                    int_id  = ID_SUB;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Integer field: sign on first non-space, decimal accumulate
    // ------------------------------------------------------------------
    logic [ACC_W-1:0] acc_e, acc_upd;
    logic             neg_e, seen_e;
    logic             is_space, first_ns, is_sign, is_digit;
    logic [ACC_W+3:0] acc_mac;
    logic [VAL_W-1:0] int_val;

    always_comb begin
        acc_e    = (pos == 3'd0) ? '0 : acc_reg;
        neg_e    = (pos == 3'd0) ? 1'b0 : neg_reg;
        seen_e   = (pos == 3'd0) ? 1'b0 : seen_reg;
        is_space = ch == CH_SPACE;
        first_ns = ~is_space & ~seen_e;
        is_sign  = first_ns & ((ch == CH_MINUS) | (ch == CH_PLUS));
        is_digit = ~is_sign & (ch >= CH_ZERO) & (ch <= CH_NINE);
        // acc*10 + digit as shift-add
        acc_mac  = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0}
                 + {(ACC_W)'(0), 4'(ch - CH_ZERO)};
        acc_upd  = is_digit ? acc_mac[ACC_W-1:0] : acc_e;
        int_val  = (neg_e | (first_ns & (ch == CH_MINUS)))
                 ? VAL_W'(0) - {1'b0, acc_upd} : {1'b0, acc_upd};
    end

    // ------------------------------------------------------------------
    // Status pair: digit value is 0 for a space, else code minus '0'
    // ------------------------------------------------------------------
    logic signed [STAT_W-1:0] d_hi, d_lo, stat_sum;
    logic        [VAL_W-1:0]  stat_val;

    always_comb begin
        d_hi     = (held_reg == CH_SPACE) ? '0
                 : $signed({5'b0, held_reg}) - $signed({5'b0, CH_ZERO});
        d_lo     = is_space ? '0
                 : $signed({5'b0, ch}) - $signed({5'b0, CH_ZERO});
        stat_sum = (d_hi <<< 3) + (d_hi <<< 1) + d_lo;
        stat_val = {{(VAL_W-STAT_W){stat_sum[STAT_W-1]}}, stat_sum};
    end

    // ------------------------------------------------------------------
    // Label: bytes in place, length excludes trailing spaces at the field end
    // ------------------------------------------------------------------
    logic [LBL_W-1:0] lab_e, lab_upd, lab_cur, lab_mask;
    logic [LEN_W-1:0] lcnt_e, lcnt_upd, lcnt_cur;

    always_comb begin
        lab_e    = (pos == 3'd0) ? '0 : lab_reg;
        lcnt_e   = (pos == 3'd0) ? '0 : lcnt_reg;
        lab_upd  = lab_e | ({{(LBL_W-8){1'b0}}, ch} << {pos, 3'b000});
        lcnt_upd = is_space ? lcnt_e : {1'b0, pos} + 4'd1;
        lab_cur  = lab_act ? lab_upd : lab_reg;
        lcnt_cur = lab_act ? lcnt_upd : lcnt_reg;
        for (int i = 0; i < 8; i++) begin
            lab_mask[i*8 +: 8] = (LEN_W'(i) < lcnt_cur) ? lab_cur[i*8 +: 8] : 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // Field RAM write
    // ------------------------------------------------------------------
    logic              wr_en;
    logic [ID_W-1:0]   wr_id;
    logic [VAL_W-1:0]  wr_val;
    logic [RAM_AW-1:0] wr_addr;

    always_comb begin
        wr_en  = 1'b0;
        wr_id  = int_id;
        wr_val = int_val;
        if (s_acc) begin
            if (int_act && pos == 3'd7) begin
                wr_en = 1'b1;
            end else if (stat_act && pos[0]) begin
                wr_en  = 1'b1;
                wr_id  = ID_STATUS_BASE + {3'b000, pos[2:1]};
                wr_val = stat_val;
            end
        end
        wr_addr = bank_reg ? RAM_AW'(wr_id) + RAM_AW'(FIELD_COUNT) : RAM_AW'(wr_id);
    end

    // ------------------------------------------------------------------
    // Parse state update
    // ------------------------------------------------------------------
    assign rec_end   = s_acc & s_tlast & on2_reg;
    assign short_rec = short1_reg | (col_inc < REC_COLS);

    always_comb begin
        on2_next    = on2_reg;
        col_next    = col_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        seen_next   = seen_reg;
        held_next   = held_reg;
        lab_next    = lab_reg;
        lcnt_next   = lcnt_reg;
        short1_next = short1_reg;
        bank_next   = bank_reg;
        if (s_acc) begin
            col_next = col_inc;
            if (int_act) begin
                acc_next  = acc_upd;
                neg_next  = neg_e | (first_ns & (ch == CH_MINUS));
                seen_next = seen_e | ~is_space;
            end
            if (stat_act && !pos[0]) begin
                held_next = ch;
            end
            if (lab_act) begin
                lab_next  = lab_upd;
                lcnt_next = lcnt_upd;
            end
            if (s_tlast) begin
                col_next = '0;
                on2_next = ~on2_reg;
                if (!on2_reg) begin
                    short1_next = col_inc < REC_COLS;
                end else begin
                    short1_next = 1'b0;
                    bank_next   = ~bank_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drain: issue reads, RAM output holds, output register
    // ------------------------------------------------------------------
    logic              issue, load;
    logic [RAM_AW-1:0] rd_addr;
    logic [VAL_W-1:0]  rd_data;

    assign load    = rd_vld_reg & (~m_vld_reg | m_tready);
    assign issue   = iss_act_reg & (~rd_vld_reg | load);
    assign rd_addr = dbank_reg ? RAM_AW'(iss_cnt_reg) + RAM_AW'(FIELD_COUNT)
                               : RAM_AW'(iss_cnt_reg);

    always_comb begin
        iss_act_next = iss_act_reg;
        iss_err_next = iss_err_reg;
        iss_cnt_next = iss_cnt_reg;
        dbank_next   = dbank_reg;
        if (rec_end) begin
            iss_act_next = 1'b1;
            iss_err_next = short_rec;
            iss_cnt_next = '0;
            dbank_next   = bank_reg;
        end else if (issue) begin
            iss_cnt_next = iss_cnt_reg + 5'd1;
            if (iss_err_reg || iss_cnt_reg == ID_LAST) begin
                iss_act_next = 1'b0;
            end
        end
        rd_vld_next = issue ? 1'b1 : (load ? 1'b0 : rd_vld_reg);
        m_vld_next  = load  ? 1'b1 : (m_tready ? 1'b0 : m_vld_reg);
    end

    fcrp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_field_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_val),
        .rd_en   (issue & ~iss_err_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on2_reg     <= 1'b0;
            col_reg     <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            seen_reg    <= 1'b0;
            held_reg    <= '0;
            lab_reg     <= '0;
            lcnt_reg    <= '0;
            short1_reg  <= 1'b0;
            bank_reg    <= 1'b0;
            iss_act_reg <= 1'b0;
            iss_err_reg <= 1'b0;
            iss_cnt_reg <= '0;
            dbank_reg   <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            on2_reg     <= on2_next;
            col_reg     <= col_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            seen_reg    <= seen_next;
            held_reg    <= held_next;
            lab_reg     <= lab_next;
            lcnt_reg    <= lcnt_next;
            short1_reg  <= short1_next;
            bank_reg    <= bank_next;
            iss_act_reg <= iss_act_next;
            iss_err_reg <= iss_err_next;
            iss_cnt_reg <= iss_cnt_next;
            dbank_reg   <= dbank_next;
            rd_vld_reg  <= rd_vld_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rec_end) begin
            snap_text_reg <= lab_mask;
            snap_len_reg  <= lcnt_cur;
        end
        if (issue) begin
            rd_id_reg  <= iss_err_reg ? '0 : iss_cnt_reg;
            rd_err_reg <= iss_err_reg;
        end
        if (load) begin
            m_id_reg   <= rd_id_reg;
            m_err_reg  <= rd_err_reg;
            m_last_reg <= rd_err_reg | (rd_id_reg == ID_LAST);
            if (rd_err_reg || rd_id_reg == ID_LABEL) begin
                m_val_reg <= '0;
            end else begin
                m_val_reg <= rd_data;
            end
            if (!rd_err_reg && rd_id_reg == ID_LABEL) begin
                m_text_reg <= snap_text_reg;
                m_len_reg  <= snap_len_reg;
            end else begin
                m_text_reg <= '0;
                m_len_reg  <= '0;
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {3'b000, m_len_reg, m_text_reg, m_val_reg, m_id_reg};
    assign m_tuser  = m_err_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the parser never writes the bank that is being drained
    a_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && drain_busy |-> wr_addr != rd_addr || bank_reg != dbank_reg)
        else $error("field write hit the bank under drain");

    a_bank_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && drain_busy |-> bank_reg != dbank_reg)
        else $error("record and drain share a RAM bank");

    // an error beat always carries last, as it is the only beat of its record
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("error beat without last");

    // read index never runs past the final field
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_act_reg |-> iss_cnt_reg <= ID_LAST)
        else $error("drain counter out of range");

endmodule
